/* rtl/quadrature_decoder_with_speed_top_defines.svh */
// assertion helpers for the quadrature decoder
`ifndef QUADRATURE_DECODER_WITH_SPEED_TOP_DEFINES_SVH
`define QUADRATURE_DECODER_WITH_SPEED_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define QDS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define QDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/qds_pkg.sv */
package qds_pkg;

    localparam int CHANNELS    = 2;
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SPEED_SCALE = 1000;
    // |delta| * 1000 stays below 2**41
    localparam int QUO_W       = 41;
    localparam int DIV_STEPS   = QUO_W;
    localparam int ITER_W      = $clog2(DIV_STEPS);

    localparam logic [1:0] FN_PIN  = 2'd0;
    localparam logic [1:0] FN_TICK = 2'd1;
    localparam logic [1:0] FN_RST  = 2'd2;

    localparam logic REG_INTERVAL = 1'b0;
    localparam logic REG_INVERT   = 1'b1;

    localparam logic [15:0] INTERVAL_RST = 16'd10;

    typedef struct packed {
        logic accept;
        logic smp_begin;
        logic delta_en;
        logic mul_en;
        logic div_step;
        logic spd_wr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic smp_hit;
        logic last_ch;
        logic out_busy;
    } t_stat;

    // x4 step from {previous A, previous B, current A, current B}
    function automatic logic signed [1:0] step_lut(input logic [3:0] idx);
        logic signed [1:0] s;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
            default: s = 2'sd0;
        endcase
        return s;
    endfunction

endpackage

/* rtl/qds_ctrl.sv */
module qds_ctrl
    import qds_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DELTA = 6'b000010,
        S_MUL   = 6'b000100,
        S_DIV   = 6'b001000,
        S_WRITE = 6'b010000,
        S_RESP  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept    = 1'b1;
                    o_cmd.smp_begin = i_stat.smp_hit;
                    n_state         = i_stat.smp_hit ? S_DELTA : S_RESP;
                end
            end
            S_DELTA: begin
                o_cmd.delta_en = 1'b1;
                n_state        = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_iter       = '0;
                n_state      = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_iter == ITER_W'(DIV_STEPS - 1)) begin
                    n_state = S_WRITE;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            S_WRITE: begin
                o_cmd.spd_wr = 1'b1;
                n_state      = i_stat.last_ch ? S_RESP : S_DELTA;
            end
            S_RESP: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

endmodule

/* rtl/qds_dp.sv */
module qds_dp
    import qds_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic [1:0]         i_func,
    input  logic               i_channel,
    input  logic               i_pin_a,
    input  logic               i_pin_b,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_pos_count,
    output logic signed [31:0] o_last_delta,
    output logic signed [31:0] o_pulse_rate,
    output logic signed [1:0]  o_dir_sign,
    output logic               o_sampled
);

    logic [15:0] r_interval;
    logic [1:0]  r_invert;
    logic [31:0] r_pos   [CHANNELS];
    logic [1:0]  r_prev  [CHANNELS];
    logic [31:0] r_cas   [CHANNELS];
    logic [31:0] r_delta [CHANNELS];
    logic [31:0] r_speed [CHANNELS];
    logic [1:0]  r_sign  [CHANNELS];
    logic [15:0] r_cnt;
    logic [15:0] r_elapsed;
    logic        r_ch;
    logic        r_sampled;
    logic [CH_W-1:0]  r_sidx;
    logic             r_neg;
    logic [31:0]      r_mag;
    logic [QUO_W-1:0] r_quo;
    logic [15:0]      r_rem;
    logic        r_out_valid;

    logic [15:0] cnt_inc;
    logic        in_ok;
    logic        out_ok;
    logic [1:0]  pins;
    logic signed [1:0] step;
    logic [31:0] step_ext;
    logic [31:0] d_cur;
    logic [16:0] trial;
    logic        ge;
    logic [31:0] quo_lo;

    assign pins    = {i_pin_a, i_pin_b};
    assign in_ok   = (32'(i_channel) < 32'(CHANNELS));
    assign out_ok  = (32'(r_ch) < 32'(CHANNELS));
    // elapsed counter saturates instead of wrapping
    assign cnt_inc = (r_cnt == 16'hFFFF) ? r_cnt : r_cnt + 16'd1;

    assign step     = step_lut({r_prev[i_channel], pins});
    assign step_ext = r_invert[i_channel] ? -{{30{step[1]}}, step} : {{30{step[1]}}, step};

    assign d_cur  = r_pos[r_sidx] - r_cas[r_sidx];
    assign trial  = {r_rem, r_quo[QUO_W-1]};
    assign ge     = (trial >= {1'b0, r_elapsed});
    assign quo_lo = r_quo[31:0];

    assign o_stat.smp_hit  = (i_func == FN_TICK) && (cnt_inc >= r_interval);
    assign o_stat.last_ch  = (r_sidx == CH_W'(CHANNELS - 1));
    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval  <= INTERVAL_RST;
            r_invert    <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_sampled   <= 1'b0;
            r_sidx      <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_pos[i]   <= '0;
                r_prev[i]  <= '0;
                r_cas[i]   <= '0;
                r_delta[i] <= '0;
                r_speed[i] <= '0;
                r_sign[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_INTERVAL: r_interval <= i_cfg_data;
                    REG_INVERT:   r_invert   <= i_cfg_data[1:0];
                    default: ;
                endcase
            end

            if (i_cmd.accept) begin
                r_ch      <= i_channel;
                r_sampled <= i_cmd.smp_begin;
                r_sidx    <= '0;
                case (i_func)
                    FN_PIN: begin
                        if (in_ok) begin
                            r_prev[i_channel] <= pins;
                            r_pos[i_channel]  <= r_pos[i_channel] + step_ext;
                        end
                    end
                    FN_TICK: begin
                        if (i_cmd.smp_begin) begin
                            r_cnt     <= '0;
                            r_elapsed <= cnt_inc;
                        end else begin
                            r_cnt <= cnt_inc;
                        end
                    end
                    FN_RST: begin
                        if (in_ok) begin
                            r_prev[i_channel]  <= pins;
                            r_pos[i_channel]   <= '0;
                            r_cas[i_channel]   <= '0;
                            r_delta[i_channel] <= '0;
                            r_speed[i_channel] <= '0;
                            r_sign[i_channel]  <= '0;
                        end
                    end
                    default: ;
                endcase
            end

            if (i_cmd.delta_en) begin
                r_cas[r_sidx]   <= r_pos[r_sidx];
                r_delta[r_sidx] <= d_cur;
                r_sign[r_sidx]  <= d_cur[31] ? 2'b11 : ((d_cur != '0) ? 2'b01 : 2'b00);
                r_neg           <= d_cur[31];
                r_mag           <= d_cur[31] ? -d_cur : d_cur;
            end

            if (i_cmd.mul_en) begin
                r_quo <= QUO_W'(QUO_W'(r_mag) * QUO_W'(SPEED_SCALE));
                r_rem <= '0;
            end

            // restoring division, one quotient bit per cycle
            if (i_cmd.div_step) begin
                r_quo <= {r_quo[QUO_W-2:0], ge};
                r_rem <= ge ? 16'(trial - {1'b0, r_elapsed}) : trial[15:0];
            end

            if (i_cmd.spd_wr) begin
                r_speed[r_sidx] <= r_neg ? -quo_lo : quo_lo;
                r_sidx          <= r_sidx + 1'b1;
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_pos_count  <= out_ok ? r_pos[r_ch]   : '0;
            o_last_delta <= out_ok ? r_delta[r_ch] : '0;
            o_pulse_rate <= out_ok ? r_speed[r_ch] : '0;
            o_dir_sign   <= out_ok ? r_sign[r_ch]  : '0;
            o_sampled    <= r_sampled;
        end
    end

endmodule

/* rtl/quadrature_decoder_with_speed_top.sv */
// channel   | handshake                 | payload
// ----------+---------------------------+---------------------------------------------
// input     | i_in_valid / o_in_ready   | i_func, i_channel, i_pin_a, i_pin_b
// result    | o_out_valid / i_out_ready | o_pos_count, o_last_delta, o_pulse_rate,
//           |                           | o_dir_sign, o_sampled
// config    | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// one item at a time: a pin, reset or plain tick item is accepted, then its result loaded
// a tick that samples runs, for each channel in turn, a delta step, a scale step, the
// 41-step restoring divider and a speed write before its result is loaded
// reset is synchronous and active low; positions, speeds and tick counts clear, interval to 10
// the result register parts the sides: a new item is taken while a result waits, and a
// stalled result only holds the next one back in its response state
`include "quadrature_decoder_with_speed_top_defines.svh"

module quadrature_decoder_with_speed_top
    import qds_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_func,
    input  logic               i_channel,
    input  logic               i_pin_a,
    input  logic               i_pin_b,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_pos_count,
    output logic signed [31:0] o_last_delta,
    output logic signed [31:0] o_pulse_rate,
    output logic signed [1:0]  o_dir_sign,
    output logic               o_sampled
);

    t_cmd  cmd;
    t_stat stat;

    qds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    qds_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_func       (i_func),
        .i_channel    (i_channel),
        .i_pin_a      (i_pin_a),
        .i_pin_b      (i_pin_b),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pos_count  (o_pos_count),
        .o_last_delta (o_last_delta),
        .o_pulse_rate (o_pulse_rate),
        .o_dir_sign   (o_dir_sign),
        .o_sampled    (o_sampled)
    );

    `QDS_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "double accept")
    `QDS_ASSERT_NOW(a_no_accept_in_divide, cmd.div_step, !o_in_ready, "input taken in divide")
    `QDS_ASSERT_NOW(a_load_into_free_slot, cmd.out_load, !o_out_valid || i_out_ready, "overwrite")
    `QDS_ASSERT_NEXT(a_load_shows_valid, cmd.out_load, o_out_valid, "loaded result not shown")

endmodule

/* dv/qds_decode_checker.sv */
module qds_decode_checker
    import qds_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_func,
    input  logic               i_channel,
    input  logic               i_pin_a,
    input  logic               i_pin_b,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_pos_count,
    input  logic signed [31:0] i_last_delta,
    input  logic signed [31:0] i_pulse_rate,
    input  logic signed [1:0]  i_dir_sign,
    input  logic               i_sampled,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_samples
);

    typedef struct {
        logic signed [31:0] pos;
        logic signed [31:0] delta;
        logic signed [31:0] speed;
        logic signed [1:0]  sign;
        logic               took;
    } t_reading;

    t_reading readings_due [$];

    logic [15:0]       interval;
    logic [1:0]        invert;
    logic [15:0]       elapsed;
    logic [31:0]       count [CHANNELS];
    logic [1:0]        last_pins [CHANNELS];
    logic [31:0]       base [CHANNELS];
    logic [31:0]       delta [CHANNELS];
    logic [31:0]       speed [CHANNELS];
    logic signed [1:0] trend [CHANNELS];
    int                errors = 0;
    int                checked = 0;
    int                samples = 0;

    task automatic report_mismatch(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // every channel latches its movement since the previous sample
    task automatic latch_speed();
        longint mv;
        longint rate;
        for (int k = 0; k < CHANNELS; k++) begin
            mv       = longint'($signed(count[k] - base[k]));
            rate     = (mv * SPEED_SCALE) / longint'(elapsed);
            delta[k] = count[k] - base[k];
            base[k]  = count[k];
            speed[k] = rate[31:0];
            trend[k] = (mv > 0) ? 2'sd1 : ((mv < 0) ? -2'sd1 : 2'sd0);
        end
    endtask

    task automatic predict_item(input logic [1:0] fn, input logic ch, input logic [1:0] pins,
                                output t_reading r);
        logic [1:0]         hop;
        logic signed [31:0] step;
        r.took = 1'b0;
        case (fn)
            FN_PIN: begin
                // distance round the gray cycle: one way counts up, the other down,
                // a double jump or no change counts nothing
                hop  = {pins[1], ^pins} - {last_pins[ch][1], ^last_pins[ch]};
                step = (hop == 2'd3) ? 32'sd1 : ((hop == 2'd1) ? -32'sd1 : 32'sd0);
                if (invert[ch])
                    step = -step;
                last_pins[ch] = pins;
                count[ch]     = count[ch] + step;
            end
            FN_TICK: begin
                if (elapsed != 16'hFFFF)
                    elapsed = elapsed + 16'd1;
                if (elapsed >= interval) begin
                    latch_speed();
                    elapsed = '0;
                    r.took  = 1'b1;
                end
            end
            FN_RST: begin
                count[ch]     = '0;
                last_pins[ch] = pins;
                base[ch]      = '0;
                delta[ch]     = '0;
                speed[ch]     = '0;
                trend[ch]     = '0;
            end
            default: begin
            end
        endcase
        r.pos   = count[ch];
        r.delta = delta[ch];
        r.speed = speed[ch];
        r.sign  = trend[ch];
    endtask

    always @(posedge i_clk) begin : watch
        t_reading want;
        t_reading fresh;
        if (!i_rst_n) begin
            interval = INTERVAL_RST;
            invert   = '0;
            elapsed  = '0;
            for (int k = 0; k < CHANNELS; k++) begin
                count[k]     = '0;
                last_pins[k] = '0;
                base[k]      = '0;
                delta[k]     = '0;
                speed[k]     = '0;
                trend[k]     = '0;
            end
            readings_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_INTERVAL)
                    interval = i_cfg_data;
                else
                    invert = i_cfg_data[1:0];
            end
            if (i_out_valid && i_out_ready) begin
                if (readings_due.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    want = readings_due.pop_front();
                    checked++;
                    if (i_pos_count !== want.pos)
                        report_mismatch($sformatf("result %0d pos_count %0d, want %0d",
                                                  checked, i_pos_count, want.pos));
                    if (i_last_delta !== want.delta)
                        report_mismatch($sformatf("result %0d last_delta %0d, want %0d",
                                                  checked, i_last_delta, want.delta));
                    if (i_pulse_rate !== want.speed)
                        report_mismatch($sformatf("result %0d pulse_rate %0d, want %0d",
                                                  checked, i_pulse_rate, want.speed));
                    if (i_dir_sign !== want.sign)
                        report_mismatch($sformatf("result %0d dir_sign %0d, want %0d",
                                                  checked, i_dir_sign, want.sign));
                    if (i_sampled !== want.took)
                        report_mismatch($sformatf("result %0d sampled %0b, want %0b",
                                                  checked, i_sampled, want.took));
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_item(i_func, i_channel, {i_pin_a, i_pin_b}, fresh);
                if (fresh.took)
                    samples++;
                readings_due.push_back(fresh);
            end
        end
        o_errors  <= errors;
        o_pending <= readings_due.size();
        o_checked <= checked;
        o_samples <= samples;
    end

endmodule

/* dv/quadrature_decoder_with_speed_top_tb.sv */
module quadrature_decoder_with_speed_top_tb;
    import qds_pkg::*;

    // func code the block leaves unused
    localparam logic [1:0] FN_SPARE    = 2'd3;
    localparam int         HOLD_CYCLES = 300;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_idx = 1'b0;
    logic [15:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         func = FN_PIN;
    logic               channel = 1'b0;
    logic               pin_a = 1'b0;
    logic               pin_b = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] pos_count;
    logic signed [31:0] last_delta;
    logic signed [31:0] pulse_rate;
    logic signed [1:0]  dir_sign;
    logic               sampled;

    int errors;
    int pending;
    int checked;
    int samples;
    int items_sent = 0;
    bit no_idle = 1'b0;
    bit hold_req = 1'b0;
    bit [1:0] pin_now [CHANNELS];
    bit       heading [CHANNELS];

    quadrature_decoder_with_speed_top u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_func       (func),
        .i_channel    (channel),
        .i_pin_a      (pin_a),
        .i_pin_b      (pin_b),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_pos_count  (pos_count),
        .o_last_delta (last_delta),
        .o_pulse_rate (pulse_rate),
        .o_dir_sign   (dir_sign),
        .o_sampled    (sampled)
    );

    qds_decode_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_func       (func),
        .i_channel    (channel),
        .i_pin_a      (pin_a),
        .i_pin_b      (pin_b),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_pos_count  (pos_count),
        .i_last_delta (last_delta),
        .i_pulse_rate (pulse_rate),
        .i_dir_sign   (dir_sign),
        .i_sampled    (sampled),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_samples    (samples)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input logic [1:0] fn, input logic ch, input logic a, input logic b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= fn;
        channel  <= ch;
        pin_a    <= a;
        pin_b    <= b;
        do begin
            @(posedge clk);
        end while (!in_ready);
        items_sent++;
        if (fn == FN_PIN || fn == FN_RST)
            pin_now[ch] = {a, b};
    endtask

    // mostly clean quadrature motion per channel, with ticks, jumps, resets and spare codes
    task automatic send_random_item();
        int         pick;
        logic       ch;
        logic [1:0] g;
        pick = $urandom_range(0, 99);
        ch   = 1'($urandom_range(0, 1));
        if (pick < 68) begin
            if ($urandom_range(0, 19) == 0)
                heading[ch] = ~heading[ch];
            g = {pin_now[ch][1], ^pin_now[ch]} + (heading[ch] ? 2'd3 : 2'd1);
            send_item(FN_PIN, ch, g[1], ^g);
        end else if (pick < 84) begin
            send_item(FN_TICK, ch, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if (pick < 92) begin
            send_item(FN_PIN, ch, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if (pick < 96) begin
            send_item(FN_RST, ch, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
            send_item(FN_SPARE, ch, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic apply_settings(input logic [15:0] interval, input logic [1:0] mask);
        logic [13:0] junk;
        junk = 14'($urandom);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_INTERVAL;
        cfg_data <= interval;
        @(posedge clk);
        cfg_idx  <= REG_INVERT;
        cfg_data <= {junk, mask};
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] interval, input logic [1:0] mask, input int n,
                             input bit calm);
        apply_settings(interval, mask);
        no_idle = calm;
        repeat (n) send_random_item();
        no_idle = 1'b0;
    endtask

    initial begin : receiver
        int stall;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
        end
    end

    initial begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // resets capture pins, then a full turn, a partial turn, illegal jumps and the spare code
        send_item(FN_RST, 1'b0, 1'b1, 1'b1);
        send_item(FN_RST, 1'b1, 1'b0, 1'b1);
        send_item(FN_PIN, 1'b0, 1'b1, 1'b0);
        send_item(FN_PIN, 1'b0, 1'b0, 1'b0);
        send_item(FN_PIN, 1'b0, 1'b0, 1'b1);
        send_item(FN_PIN, 1'b0, 1'b1, 1'b1);
        send_item(FN_PIN, 1'b0, 1'b0, 1'b0);
        send_item(FN_PIN, 1'b0, 1'b1, 1'b1);
        send_item(FN_PIN, 1'b1, 1'b0, 1'b0);
        send_item(FN_PIN, 1'b1, 1'b1, 1'b0);
        send_item(FN_PIN, 1'b1, 1'b1, 1'b1);
        send_item(FN_SPARE, 1'b0, 1'b1, 1'b1);
        send_item(FN_SPARE, 1'b1, 1'b0, 1'b0);

        // short interval with the right channel inverted
        apply_settings(16'd3, 2'b10);
        send_item(FN_TICK, 1'b0, 1'b0, 1'b0);
        send_item(FN_TICK, 1'b1, 1'b1, 1'b1);
        send_item(FN_TICK, 1'b0, 1'b1, 1'b0);
        send_item(FN_PIN, 1'b1, 1'b0, 1'b1);
        send_item(FN_PIN, 1'b1, 1'b0, 1'b0);
        send_item(FN_PIN, 1'b0, 1'b0, 1'b1);
        send_item(FN_TICK, 1'b1, 1'b0, 1'b1);
        send_item(FN_TICK, 1'b1, 1'b1, 1'b0);
        send_item(FN_TICK, 1'b1, 1'b1, 1'b1);
        send_item(FN_RST, 1'b1, 1'b1, 1'b0);
        send_item(FN_TICK, 1'b0, 1'b0, 1'b1);

        run_phase(16'd1, 2'b00, 200, 1'b0);
        run_phase(16'd2, 2'b11, 250, 1'b1);
        run_phase(16'd7, 2'b01, 150, 1'b0);
        // results back up behind a stalled receiver until the input stalls too
        hold_req = 1'b1;
        repeat (150) send_random_item();
        run_phase(16'd10, 2'b10, 150, 1'b0);
        wait_drained();
        repeat (150) send_random_item();
        run_phase(16'd37, 2'b00, 100, 1'b1);
        run_phase(16'd200, 2'b11, 150, 1'b0);
        // interval may now be below the elapsed count, so the next tick then samples on it
        run_phase(16'd5, 2'b01, 200, 1'b0);
        run_phase(16'd0, 2'b11, 60, 1'b0);

        // widest interval: ticks only build up the elapsed count
        apply_settings(16'hFFFF, 2'b01);
        no_idle = 1'b1;
        repeat (60) send_random_item();
        no_idle = 1'b0;
        run_phase(16'd3, 2'($urandom_range(0, 3)), 100, 1'b0);

        wait_drained();
        repeat (100) @(posedge clk);
        $display("covered %0d items, %0d results checked, %0d of them speed samples",
                 items_sent, checked, samples);
        $display("intervals 0 to 65535, all invert masks, receiver hold-off and a full drain");
        if (errors == 0 && pending == 0)
            $display("[quadrature_decoder_with_speed_top] OK");
        else
            $display("[quadrature_decoder_with_speed_top] ERROR");
        $finish;
    end

    initial begin : watchdog
        #40_000_000;
        $display("[quadrature_decoder_with_speed_top] ERROR");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/qds_pkg.sv
rtl/qds_ctrl.sv
rtl/qds_dp.sv
rtl/quadrature_decoder_with_speed_top.sv
dv/qds_decode_checker.sv
dv/quadrature_decoder_with_speed_top_tb.sv
